[hw/rtl/text_console_writer_core_assert.svh]
// text_console_writer_core_assert.svh: assertion macros for the console writer
// plain header, no dependencies; included by the top level

`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define TCW_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define TCW_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/tcw_pkg.sv]
// tcw_pkg.sv: shared widths, codes, microcode step map and control store
// no dependencies; used by the interfaces, the sequencer and the top level
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // payload field widths
  localparam int unsigned CmdW  = 2;
  localparam int unsigned CharW = 8;
  localparam int unsigned IdxW  = 11;
  localparam int unsigned DataW = 16;
  localparam int unsigned CurW  = 11;

  // command codes
  localparam logic [CmdW-1:0] CMD_PUT   = 2'd0;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;

  // character and cell constants
  localparam logic [CharW-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CharW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0]       TEXT_ATTR  = 8'h07;
  localparam logic [DataW-1:0] BLANK_CELL = 16'h0720;

  // microcode step addresses
  localparam int unsigned StepW = 5;
  typedef logic [StepW-1:0] tcw_step_t;

  localparam tcw_step_t U_IDLE     = 5'd0;
  localparam tcw_step_t U_DISP_PUT = 5'd1;
  localparam tcw_step_t U_DISP_RD  = 5'd2;
  localparam tcw_step_t U_DISP_CLR = 5'd3;
  localparam tcw_step_t U_CMD_NONE = 5'd4;
  localparam tcw_step_t U_PUT      = 5'd5;
  localparam tcw_step_t U_PUT_CHK  = 5'd6;
  localparam tcw_step_t U_SC_INIT  = 5'd7;
  localparam tcw_step_t U_SC_RD    = 5'd8;
  localparam tcw_step_t U_SC_WR    = 5'd9;
  localparam tcw_step_t U_SC_BL    = 5'd10;
  localparam tcw_step_t U_SC_ROW   = 5'd11;
  localparam tcw_step_t U_PUTCH    = 5'd12;
  localparam tcw_step_t U_PUB      = 5'd13;
  localparam tcw_step_t U_RD       = 5'd14;
  localparam tcw_step_t U_RD_CAP   = 5'd15;
  localparam tcw_step_t U_CLR      = 5'd16;
  localparam tcw_step_t U_CLR_BL   = 5'd17;
  localparam tcw_step_t U_WAIT     = 5'd18;
  localparam tcw_step_t U_EMIT     = 5'd19;
  localparam tcw_step_t U_RST_BL   = 5'd20;
  localparam tcw_step_t U_RST_END  = 5'd21;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_PTR_ZERO,
    OP_SC_READ,
    OP_SC_WRITE,
    OP_BLANK_WRITE,
    OP_ROW_LAST,
    OP_PUT_CHAR,
    OP_PUBLISH_EOS,
    OP_MEM_READ,
    OP_READ_CAPTURE,
    OP_CLEAR_INIT,
    OP_EMIT
  } tcw_op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_CMD_PUT,
    C_CMD_READ,
    C_CMD_CLEAR,
    C_CHAR_ZERO,
    C_NO_SCROLL,
    C_MOVE_MORE,
    C_BLANK_MORE,
    C_OUT_BUSY
  } tcw_cond_e;

  // one control word
  typedef struct packed {
    logic      ready;
    tcw_op_e   op;
    tcw_cond_e cond;
    tcw_step_t target;
  } tcw_uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic cmd_put;
    logic cmd_read;
    logic cmd_clear;
    logic char_zero;
    logic no_scroll;
    logic move_more;
    logic blank_more;
    logic out_busy;
  } tcw_flags_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic    in_ready;
    tcw_op_e op;
  } tcw_ctrl_t;

  // control store
  function automatic tcw_uword_t tcw_ucode(tcw_step_t step);
    tcw_uword_t w;
    case (step)
      U_IDLE:     w = '{1'b1, OP_LATCH,        C_NO_ACCEPT,  U_IDLE};
      U_DISP_PUT: w = '{1'b0, OP_NOP,          C_CMD_PUT,    U_PUT};
      U_DISP_RD:  w = '{1'b0, OP_NOP,          C_CMD_READ,   U_RD};
      U_DISP_CLR: w = '{1'b0, OP_NOP,          C_CMD_CLEAR,  U_CLR};
      U_CMD_NONE: w = '{1'b0, OP_NOP,          C_ALWAYS,     U_WAIT};
      U_PUT:      w = '{1'b0, OP_NOP,          C_CHAR_ZERO,  U_PUB};
      U_PUT_CHK:  w = '{1'b0, OP_NOP,          C_NO_SCROLL,  U_PUTCH};
      U_SC_INIT:  w = '{1'b0, OP_PTR_ZERO,     C_NEVER,      U_IDLE};
      U_SC_RD:    w = '{1'b0, OP_SC_READ,      C_NEVER,      U_IDLE};
      U_SC_WR:    w = '{1'b0, OP_SC_WRITE,     C_MOVE_MORE,  U_SC_RD};
      U_SC_BL:    w = '{1'b0, OP_BLANK_WRITE,  C_BLANK_MORE, U_SC_BL};
      U_SC_ROW:   w = '{1'b0, OP_ROW_LAST,     C_NEVER,      U_IDLE};
      U_PUTCH:    w = '{1'b0, OP_PUT_CHAR,     C_NEVER,      U_IDLE};
      U_PUB:      w = '{1'b0, OP_PUBLISH_EOS,  C_ALWAYS,     U_WAIT};
      U_RD:       w = '{1'b0, OP_MEM_READ,     C_NEVER,      U_IDLE};
      U_RD_CAP:   w = '{1'b0, OP_READ_CAPTURE, C_ALWAYS,     U_WAIT};
      U_CLR:      w = '{1'b0, OP_CLEAR_INIT,   C_NEVER,      U_IDLE};
      U_CLR_BL:   w = '{1'b0, OP_BLANK_WRITE,  C_BLANK_MORE, U_CLR_BL};
      U_WAIT:     w = '{1'b0, OP_NOP,          C_OUT_BUSY,   U_WAIT};
      U_EMIT:     w = '{1'b0, OP_EMIT,         C_ALWAYS,     U_IDLE};
      U_RST_BL:   w = '{1'b0, OP_BLANK_WRITE,  C_BLANK_MORE, U_RST_BL};
      U_RST_END:  w = '{1'b0, OP_NOP,          C_ALWAYS,     U_IDLE};
      default:    w = '{1'b0, OP_NOP,          C_ALWAYS,     U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcw_if.sv]
// tcw_if.sv: valid/ready channels for command words and result words
// depends on tcw_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CmdW-1:0]    cmd;
  logic [tcw_pkg::CharW-1:0]   char_code;
  logic                        end_of_string;
  logic [tcw_pkg::IdxW-1:0]    cell_index;

  modport source (output valid, cmd, char_code, end_of_string, cell_index, input ready);
  modport sink   (input valid, cmd, char_code, end_of_string, cell_index, output ready);
endinterface

// result channel
interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::DataW-1:0]   cell_data;
  logic [tcw_pkg::CurW-1:0]    cursor_location;

  modport source (output valid, cell_data, cursor_location, input ready);
  modport sink   (input valid, cell_data, cursor_location, output ready);
endinterface

`default_nettype wire

[hw/rtl/tcw_screen_ram.sv]
// tcw_screen_ram.sv: screen cell store, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = 11,
  parameter int unsigned DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcw_sequencer.sv]
// tcw_sequencer.sv: step counter, control store lookup and jump logic
// depends on tcw_pkg for the control word, conditions and step map
`timescale 1ns / 1ps
`default_nettype none

module tcw_sequencer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcw_pkg::tcw_flags_t flags_i,
  output tcw_pkg::tcw_ctrl_t       ctrl_o
);

  tcw_pkg::tcw_step_t  upc_q, upc_d;
  tcw_pkg::tcw_uword_t word;
  logic                take;

  // fetch the control word for the current step
  assign word = tcw_pkg::tcw_ucode(upc_q);

  // evaluate the jump condition
  always_comb begin
    case (word.cond)
      tcw_pkg::C_NEVER:      take = 1'b0;
      tcw_pkg::C_ALWAYS:     take = 1'b1;
      tcw_pkg::C_NO_ACCEPT:  take = !(flags_i.in_valid && word.ready);
      tcw_pkg::C_CMD_PUT:    take = flags_i.cmd_put;
      tcw_pkg::C_CMD_READ:   take = flags_i.cmd_read;
      tcw_pkg::C_CMD_CLEAR:  take = flags_i.cmd_clear;
      tcw_pkg::C_CHAR_ZERO:  take = flags_i.char_zero;
      tcw_pkg::C_NO_SCROLL:  take = flags_i.no_scroll;
      tcw_pkg::C_MOVE_MORE:  take = flags_i.move_more;
      tcw_pkg::C_BLANK_MORE: take = flags_i.blank_more;
      tcw_pkg::C_OUT_BUSY:   take = flags_i.out_busy;
      default:               take = 1'b0;
    endcase
  end

  // next step: jump target or fall through
  assign upc_d = take ? word.target : upc_q + 1'b1;

  // reset enters the power-up blanking pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= tcw_pkg::U_RST_BL;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.in_ready = word.ready;
  assign ctrl_o.op       = word.op;

endmodule

`default_nettype wire

[hw/rtl/text_console_writer_core.sv]
// text_console_writer_core.sv: text console top level, cursor datapath and output register
// depends on tcw_pkg, tcw_if, tcw_screen_ram, tcw_sequencer and the assertion header
//
//   channel  dir  handshake    word fields
//   cmd_i    in   valid/ready  cmd, char_code, end_of_string, cell_index
//   res_o    out  valid/ready  cell_data, cursor_location
//
// one word at a time, from acceptance to next ready; a clear blanks every cell, and a put
// that carries out a pending scroll adds a read and a write step per moved cell on the
// single read and single write port of the cell store, then blanks the last row
// after reset a blanking pass over every cell runs before the first word is taken; a
// stalled result holds in the output register while the next word runs
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_core_assert.svh"

module text_console_writer_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcw_in_if.sink    cmd_i,
  tcw_out_if.source res_o
);

  localparam int unsigned Cells   = ROWS * COLUMNS;
  localparam int unsigned AddrW   = $clog2(Cells);
  localparam int unsigned ColW    = $clog2(COLUMNS);
  localparam int unsigned RowW    = $clog2(ROWS + 1);
  localparam int unsigned LinW    = $clog2((ROWS + 1) * COLUMNS);
  localparam int unsigned IdxExtW = AddrW + tcw_pkg::IdxW;
  localparam int unsigned LinExtW = LinW + tcw_pkg::CurW;

  tcw_pkg::tcw_ctrl_t  ctrl;
  tcw_pkg::tcw_flags_t flags;
  logic                accept;

  // latched command word
  logic [tcw_pkg::CmdW-1:0]  cmd_q, cmd_d;
  logic [tcw_pkg::CharW-1:0] char_q, char_d;
  logic                      eos_q, eos_d;
  logic [tcw_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [tcw_pkg::DataW-1:0] data_q, data_d;

  // cursor and sweep pointer
  logic [ColW-1:0]           col_q, col_d;
  logic [RowW-1:0]           row_q, row_d;
  logic [tcw_pkg::CurW-1:0]  pub_q, pub_d;
  logic [AddrW-1:0]          ptr_q, ptr_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [tcw_pkg::DataW-1:0] out_data_q, out_data_d;
  logic [tcw_pkg::CurW-1:0]  out_cur_q, out_cur_d;

  // cell store port
  logic                      ram_we, ram_re;
  logic [AddrW-1:0]          ram_waddr, ram_raddr;
  logic [tcw_pkg::DataW-1:0] ram_wdata, ram_rdata;

  // derived addresses
  logic [LinW-1:0]           cur_lin;
  logic [LinExtW-1:0]        lin_ext;
  logic [tcw_pkg::CurW-1:0]  cur_pub;
  logic [IdxExtW-1:0]        idx_ext;
  logic                      idx_in_range;

  assign accept = cmd_i.valid && ctrl.in_ready;

  // cursor as linear cell address and as published value
  assign cur_lin = LinW'(row_q) * LinW'(COLUMNS) + LinW'(col_q);
  assign lin_ext = LinExtW'(cur_lin);
  assign cur_pub = lin_ext[tcw_pkg::CurW-1:0];

  // read index range check
  assign idx_ext      = IdxExtW'(idx_q);
  assign idx_in_range = idx_ext < IdxExtW'(Cells);

  // status for the sequencer
  always_comb begin
    flags.in_valid   = cmd_i.valid;
    flags.cmd_put    = cmd_q == tcw_pkg::CMD_PUT;
    flags.cmd_read   = cmd_q == tcw_pkg::CMD_READ;
    flags.cmd_clear  = cmd_q == tcw_pkg::CMD_CLEAR;
    flags.char_zero  = char_q == tcw_pkg::CHAR_NUL;
    flags.no_scroll  = row_q < RowW'(ROWS);
    flags.move_more  = ptr_q != AddrW'(Cells - COLUMNS - 1);
    flags.blank_more = ptr_q != AddrW'(Cells - 1);
    flags.out_busy   = out_valid_q && !res_o.ready;
  end

  tcw_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  tcw_screen_ram #(
    .Depth (Cells),
    .AddrW (AddrW),
    .DataW (tcw_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // datapath operations
  always_comb begin
    cmd_d       = cmd_q;
    char_d      = char_q;
    eos_d       = eos_q;
    idx_d       = idx_q;
    data_d      = data_q;
    col_d       = col_q;
    row_d       = row_q;
    pub_d       = pub_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_data_d  = out_data_q;
    out_cur_d   = out_cur_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ptr_q;
    ram_raddr   = ptr_q;
    ram_wdata   = tcw_pkg::BLANK_CELL;

    case (ctrl.op)
      tcw_pkg::OP_LATCH: begin
        if (accept) begin
          cmd_d  = cmd_i.cmd;
          char_d = cmd_i.char_code;
          eos_d  = cmd_i.end_of_string;
          idx_d  = cmd_i.cell_index;
          data_d = '0;
        end
      end
      tcw_pkg::OP_PTR_ZERO: begin
        ptr_d = '0;
      end
      tcw_pkg::OP_SC_READ: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q + AddrW'(COLUMNS);
      end
      tcw_pkg::OP_SC_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_q + 1'b1;
      end
      tcw_pkg::OP_BLANK_WRITE: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
      end
      tcw_pkg::OP_ROW_LAST: begin
        row_d = RowW'(ROWS - 1);
      end
      tcw_pkg::OP_PUT_CHAR: begin
        // newline, carriage return or a cell write for any other character
        if (char_q == tcw_pkg::CHAR_LF) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else if (char_q != tcw_pkg::CHAR_CR) begin
          ram_we    = 1'b1;
          ram_waddr = cur_lin[AddrW-1:0];
          ram_wdata = {tcw_pkg::TEXT_ATTR, char_q};
          if (col_q == ColW'(COLUMNS - 1)) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      tcw_pkg::OP_PUBLISH_EOS: begin
        if (eos_q) begin
          pub_d = cur_pub;
        end
      end
      tcw_pkg::OP_MEM_READ: begin
        ram_re    = idx_in_range;
        ram_raddr = idx_ext[AddrW-1:0];
      end
      tcw_pkg::OP_READ_CAPTURE: begin
        data_d = idx_in_range ? ram_rdata : '0;
      end
      tcw_pkg::OP_CLEAR_INIT: begin
        ptr_d = '0;
        col_d = '0;
        row_d = '0;
        pub_d = '0;
      end
      tcw_pkg::OP_EMIT: begin
        out_valid_d = 1'b1;
        out_data_d  = data_q;
        out_cur_d   = pub_q;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pub_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      pub_q       <= pub_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    char_q     <= char_d;
    eos_q      <= eos_d;
    idx_q      <= idx_d;
    data_q     <= data_d;
    out_data_q <= out_data_d;
    out_cur_q  <= out_cur_d;
  end

  // channel outputs
  assign cmd_i.ready           = ctrl.in_ready;
  assign res_o.valid           = out_valid_q;
  assign res_o.cell_data       = out_data_q;
  assign res_o.cursor_location = out_cur_q;

  // checks
  `TCW_ASSERT(a_row_bound, clk_i, rst_ni, row_q <= RowW'(ROWS), "cursor row past scroll limit")
  `TCW_ASSERT(a_write_in_range, clk_i, rst_ni, !ram_we || (32'(ram_waddr) < Cells),
              "cell write out of range")
  `TCW_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, accept, !ctrl.in_ready, "word taken while busy")
  `TCW_ASSERT(a_emit_free, clk_i, rst_ni,
              (ctrl.op != tcw_pkg::OP_EMIT) || !res_o.valid || res_o.ready,
              "result overwrites a stalled word")

endmodule

`default_nettype wire

[bench/text_console_writer_core_test.sv]
// text_console_writer_core_test.sv: self-checking bench for the text console writer core
// depends on tcw_pkg, tcw_if and the rtl of text_console_writer_core
// a screen predictor runs on each accepted command word and checks every result word
`timescale 1ns / 1ps

module text_console_writer_core_test;

  localparam int unsigned COLS  = 80;
  localparam int unsigned ROWS  = 25;
  localparam int unsigned CELLS = ROWS * COLS;

  // the fourth command code has no function
  localparam logic [tcw_pkg::CmdW-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned TOTAL_WORDS = 1950;
  // longest correct silence is a scroll plus stalls
  localparam int unsigned STALL_LIMIT = 40000;

  typedef struct packed {
    logic [tcw_pkg::DataW-1:0] cell_data;
    logic [tcw_pkg::CurW-1:0]  cursor_location;
  } console_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcw_in_if  cmd_if ();
  tcw_out_if res_if ();

  text_console_writer_core #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // screen predictor state
  logic [tcw_pkg::DataW-1:0] screen_model [CELLS];
  int unsigned               cur_col;
  int unsigned               cur_row;
  logic [tcw_pkg::CurW-1:0]  shown_cursor;

  console_result_t pending_results [$];
  int unsigned     error_count;
  int unsigned     words_sent;
  int unsigned     idle_cycles;
  int unsigned     rx_stall_left;
  bit              tx_gaps_on;
  bit              rx_stalls_on;

  // predictor
  function automatic void model_blank();
    for (int i = 0; i < CELLS; i++) screen_model[i] = tcw_pkg::BLANK_CELL;
  endfunction

  function automatic void model_publish();
    shown_cursor = tcw_pkg::CurW'(cur_row * COLS + cur_col);
  endfunction

  function automatic void model_char(logic [tcw_pkg::CharW-1:0] ch);
    // pending scroll is carried out before any nonzero character
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = tcw_pkg::BLANK_CELL;
      cur_row = ROWS - 1;
    end
    if (ch == tcw_pkg::CHAR_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (ch != tcw_pkg::CHAR_CR) begin
      screen_model[cur_row * COLS + cur_col] = {tcw_pkg::TEXT_ATTR, ch};
      cur_col++;
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
      end
    end
  endfunction

  function automatic console_result_t model_word(
      logic [tcw_pkg::CmdW-1:0] cmd, logic [tcw_pkg::CharW-1:0] ch, logic eos,
      logic [tcw_pkg::IdxW-1:0] idx);
    console_result_t r;
    r.cell_data = '0;
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (ch != tcw_pkg::CHAR_NUL) model_char(ch);
        if (eos) model_publish();
      end
      tcw_pkg::CMD_READ: begin
        if (idx < CELLS) r.cell_data = screen_model[idx];
      end
      tcw_pkg::CMD_CLEAR: begin
        model_blank();
        cur_col = 0;
        cur_row = 0;
        model_publish();
      end
      default: ;
    endcase
    r.cursor_location = shown_cursor;
    return r;
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one command word and predict its result at acceptance
  task automatic send_word(logic [tcw_pkg::CmdW-1:0] cmd, logic [tcw_pkg::CharW-1:0] ch,
                           logic eos, logic [tcw_pkg::IdxW-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.cmd           <= cmd;
    cmd_if.char_code     <= ch;
    cmd_if.end_of_string <= eos;
    cmd_if.cell_index    <= idx;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_results.push_back(model_word(cmd, ch, eos, idx));
    words_sent++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.cell_data !== want.cell_data) begin
          $error("cell_data expected %h actual %h", want.cell_data, res_if.cell_data);
          error_count++;
        end
        if (res_if.cursor_location !== want.cursor_location) begin
          $error("cursor_location expected %0d actual %0d",
                 want.cursor_location, res_if.cursor_location);
          error_count++;
        end
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (rx_stall_left != 0) begin
      res_if.ready  <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
      res_if.ready  <= 1'b0;
      rx_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(19, 79)
                                                   : $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // a first read, plain characters, edge codes, nul, carriage return, newline, publishing
  task automatic test_put_basics();
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd0);
    send_word(tcw_pkg::CMD_PUT, 8'h41, 1'b0, 11'h7ff);
    send_word(tcw_pkg::CMD_PUT, 8'hff, 1'b1, 11'd0);
    send_word(tcw_pkg::CMD_PUT, 8'h80, 1'b0, 11'h400);
    send_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NUL, 1'b1, 11'd5);
    send_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_CR, 1'b1, 11'd0);
    send_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_LF, 1'b1, 11'd0);
    send_word(tcw_pkg::CMD_PUT, 8'h7f, 1'b1, 11'd0);
    send_word(tcw_pkg::CMD_PUT, 8'h01, 1'b0, 11'd0);
  endtask

  // cells just written, last cell, out of range, top index bit
  task automatic test_reads();
    send_word(tcw_pkg::CMD_READ, 8'hff, 1'b1, 11'd0);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd1);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd2);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd80);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd1999);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd2000);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'h7ff);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'h400);
  endtask

  task automatic test_unused_command();
    send_word(CMD_UNUSED, 8'hff, 1'b1, 11'h7ff);
  endtask

  task automatic test_clear();
    send_word(tcw_pkg::CMD_CLEAR, 8'h55, 1'b1, 11'h2aa);
    send_word(tcw_pkg::CMD_READ, 8'h00, 1'b0, 11'd0);
    send_word(tcw_pkg::CMD_PUT, 8'h01, 1'b1, 11'd0);
  endtask

  // lines of random text, read bursts, newline runs, clears and noise
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned len;
    int          base;
    logic [tcw_pkg::CharW-1:0] ch;
    logic        eos;
    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // a line of text, sometimes long enough to wrap
        pick = $urandom_range(0, 9);
        len = (pick < 7) ? $urandom_range(0, 15) :
              (pick < 9) ? $urandom_range(16, 60) : $urandom_range(70, 170);
        for (int i = 0; i < len; i++) begin
          ch = 8'($urandom_range(1, 255));
          if (ch == tcw_pkg::CHAR_LF) ch = 8'h20;
          pick = $urandom_range(0, 39);
          if (pick == 0) ch = tcw_pkg::CHAR_NUL;
          else if (pick == 1) ch = tcw_pkg::CHAR_CR;
          eos = (i == len - 1) || ($urandom_range(0, 3) == 0);
          send_word(tcw_pkg::CMD_PUT, ch, eos, tcw_pkg::IdxW'($urandom));
        end
        if ($urandom_range(0, 9) != 0)
          send_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_LF, 1'($urandom_range(0, 1)),
                    tcw_pkg::IdxW'($urandom));
      end else if (pick < 70) begin
        // reads around the cursor, anywhere, or past the end
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 9);
          base = int'(cur_row * COLS + cur_col) - int'($urandom_range(0, 3 * COLS));
          if (base < 0) base = 0;
          if (pick >= 6) base = $urandom_range(0, 2047);
          if (pick == 9) base = $urandom_range(CELLS, 2047);
          send_word(tcw_pkg::CMD_READ, tcw_pkg::CharW'($urandom), 1'($urandom_range(0, 1)),
                    tcw_pkg::IdxW'(base));
        end
      end else if (pick < 73) begin
        // newline run to reach the bottom and scroll
        len = $urandom_range(3, 15);
        for (int i = 0; i < len; i++)
          send_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_LF, 1'($urandom_range(0, 1)),
                    tcw_pkg::IdxW'($urandom));
      end else if (pick < 75) begin
        send_word(tcw_pkg::CMD_CLEAR, tcw_pkg::CharW'($urandom), 1'($urandom_range(0, 1)),
                  tcw_pkg::IdxW'($urandom));
      end else begin
        // raw words with every field random
        send_word(tcw_pkg::CmdW'($urandom), tcw_pkg::CharW'($urandom),
                  1'($urandom_range(0, 1)), tcw_pkg::IdxW'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = tcw_pkg::CMD_PUT;
    cmd_if.char_code     = '0;
    cmd_if.end_of_string = 1'b0;
    cmd_if.cell_index    = '0;
    res_if.ready         = 1'b0;
    error_count          = 0;
    words_sent           = 0;
    idle_cycles          = 0;
    rx_stall_left        = 0;
    tx_gaps_on           = 1'b0;
    rx_stalls_on         = 1'b0;
    model_blank();
    cur_col      = 0;
    cur_row      = 0;
    shown_cursor = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_put_basics();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    test_reads();
    test_unused_command();
    test_clear();
    test_random_traffic();

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[text_console_writer_core.f]
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_screen_ram.sv
hw/rtl/tcw_sequencer.sv
hw/rtl/text_console_writer_core.sv
bench/text_console_writer_core_test.sv
